@@ rtl/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

    // result codes
    localparam logic [1:0] EV_BYTE = 2'd0;
    localparam logic [1:0] EV_DONE = 2'd1;
    localparam logic [1:0] EV_ERR  = 2'd2;

    // mode codes
    localparam logic [2:0] M_WAIT = 3'd0;
    localparam logic [2:0] M_STR  = 3'd1;
    localparam logic [2:0] M_ESC  = 3'd2;
    localparam logic [2:0] M_HEX  = 3'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;

    localparam int MAX_RES     = 3;
    localparam int QUEUE_DEPTH = 8;

    typedef struct packed {
        logic [1:0] ev;
        logic [7:0] data;
        logic       last;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            h.value = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            h.value = 4'(b - 8'h37);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/json_string_unescaper_top.sv @@
// json string unescaper
// input channel: in_byte/in_last with in_valid and in_stall. bytes of one quoted
// string arrive starting at the opening quote; in_last flags the end of the text.
// output channel: event_res/out_byte/run_last with out_valid and out_stall. each
// item gives zero to three results; run_last marks the final result of an item.
// event_res is byte, done (closing quote) or error (no opening quote or truncated).
// results enter the queue when their item is accepted; the output shows its head.
// throughput: one item per cycle while in_stall is low. the decode is a single
// combinational pass from the state registers into an 8-entry result queue that takes
// up to three writes per cycle; in_stall rises while fewer than three queue entries are
// free, which happens only while the receiver holds off (a \u burst of three bytes alone
// never fills it, since a \u takes six items and the queue drains one result per cycle).
// when the receiver stalls, the head result stays on the output ports unchanged
// and the queue keeps absorbing items until it runs short of room.
// reset clears the queue and returns the decoder to waiting for an opening quote.
`default_nettype none
module json_string_unescaper_top
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      event_res,
    output logic [7:0]      out_byte,
    output logic            run_last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(QUEUE_DEPTH - MAX_RES);

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_reg, code_next;
    logic        stopped_reg, stopped_next;

    res_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    res_t        res [MAX_RES];
    logic [1:0]  n_res;
    hex_t        digit;
    logic [15:0] code_acc;
    logic        accept, pop;

    assign accept   = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;
    assign in_stall = count_reg > STALL_LEVEL;

    assign digit    = hex_digit(in_byte);
    assign code_acc = (!stopped_reg && digit.valid) ? {code_reg[11:0], digit.value} : code_reg;

    always_comb
    begin
        mode_next      = mode_reg;
        hex_count_next = hex_count_reg;
        code_next      = code_reg;
        stopped_next   = stopped_reg;
        n_res          = 2'd0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k] = '0;
        end

        unique case (mode_reg)
            M_STR:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    res[0].ev = EV_DONE;
                    n_res     = 2'd1;
                    mode_next = M_WAIT;
                end
                else if (in_last)
                begin
                    res[0].ev = EV_ERR;
                    n_res     = 2'd1;
                    mode_next = M_WAIT;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = M_ESC;
                end
                else
                begin
                    res[0].ev   = EV_BYTE;
                    res[0].data = in_byte;
                    n_res       = 2'd1;
                end
            end
            M_ESC:
            begin
                if (in_last)
                begin
                    res[0].ev = EV_ERR;
                    n_res     = 2'd1;
                    mode_next = M_WAIT;
                end
                else if (in_byte == CH_U)
                begin
                    hex_count_next = 2'd0;
                    code_next      = 16'd0;
                    stopped_next   = 1'b0;
                    mode_next      = M_HEX;
                end
                else
                begin
                    res[0].ev   = EV_BYTE;
                    res[0].data = map_escape(in_byte);
                    n_res       = 2'd1;
                    mode_next   = M_STR;
                end
            end
            M_HEX:
            begin
                if (in_last)
                begin
                    res[0].ev      = EV_ERR;
                    n_res          = 2'd1;
                    hex_count_next = 2'd0;
                    code_next      = 16'd0;
                    stopped_next   = 1'b0;
                    mode_next      = M_WAIT;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    // fourth hex character: emit the code point as utf-8
                    if (code_acc < UTF_ONE_LIMIT)
                    begin
                        res[0].data = code_acc[7:0];
                        n_res       = 2'd1;
                    end
                    else if (code_acc < UTF_TWO_LIMIT)
                    begin
                        res[0].data = UTF_LEAD2 | {3'b000, code_acc[10:6]};
                        res[1].data = UTF_CONT | {2'b00, code_acc[5:0]};
                        n_res       = 2'd2;
                    end
                    else
                    begin
                        res[0].data = UTF_LEAD3 | {4'b0000, code_acc[15:12]};
                        res[1].data = UTF_CONT | {2'b00, code_acc[11:6]};
                        res[2].data = UTF_CONT | {2'b00, code_acc[5:0]};
                        n_res       = 2'd3;
                    end
                    hex_count_next = 2'd0;
                    code_next      = 16'd0;
                    stopped_next   = 1'b0;
                    mode_next      = M_STR;
                end
                else
                begin
                    code_next      = code_acc;
                    stopped_next   = stopped_reg || !digit.valid;
                    hex_count_next = hex_count_reg + 2'd1;
                end
            end
            default:
            begin
                if (in_byte != CH_QUOTE || in_last)
                begin
                    res[0].ev = EV_ERR;
                    n_res     = 2'd1;
                    mode_next = M_WAIT;
                end
                else
                begin
                    mode_next = M_STR;
                end
            end
        endcase

        for (int k = 0; k < MAX_RES; k++)
        begin
            res[k].last = (32'(n_res) == k + 1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + CNT_W'(n_res);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_WAIT;
            hex_count_reg <= 2'd0;
            code_reg      <= 16'd0;
            stopped_reg   <= 1'b0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg      <= mode_next;
                hex_count_reg <= hex_count_next;
                code_reg      <= code_next;
                stopped_reg   <= stopped_next;
                wr_ptr_reg    <= wr_ptr_reg + PTR_W'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // result queue payload, up to three writes per item
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (accept && (k < 32'(n_res)))
            begin
                queue_reg[wr_ptr_reg + PTR_W'(k)] <= res[k];
            end
        end
    end

    assign out_valid = count_reg != '0;
    assign event_res = queue_reg[rd_ptr_reg].ev;
    assign out_byte  = queue_reg[rd_ptr_reg].data;
    assign run_last  = queue_reg[rd_ptr_reg].last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> count_reg <= STALL_LEVEL)
        else $error("item accepted without room for its results");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !accept) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("queue count did not drop on pop");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_BYTE) |-> (out_byte == 8'd0 && run_last))
        else $error("done or error result carries data or is not last");

    a_hex_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_HEX) |-> (hex_count_reg == 2'd0 && !stopped_reg))
        else $error("hex state left over outside a unicode escape");

endmodule
`default_nettype wire

@@ test/json_string_unescaper_top_tb.sv @@
`default_nettype none
module json_string_unescaper_top_tb;
    import jsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_ROWS    = 28;
    localparam int RAND_ITEMS  = 190;
    localparam int HOLD_CYCLES = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    // escape letters and the control characters they stand for
    localparam logic [7:0] ESC_B    = "b";
    localparam logic [7:0] ESC_F    = "f";
    localparam logic [7:0] ESC_N    = "n";
    localparam logic [7:0] ESC_R    = "r";
    localparam logic [7:0] ESC_T    = "t";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CTL_BS   = 8'h08;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_LF   = 8'h0A;
    localparam logic [7:0] CTL_CR   = 8'h0D;
    localparam logic [7:0] CTL_TAB  = 8'h09;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        res_t       want;
    } stim_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] event_res;
    logic [7:0] out_byte;
    logic       run_last;

    json_string_unescaper_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    // decoder copy
    logic [2:0]  dec_mode;
    logic [1:0]  dec_hex_cnt;
    logic [15:0] dec_code;
    logic        dec_hex_stop;
    res_t        dec_res [3];
    int          dec_n;

    res_t  expected_q [$];
    stim_t stim_q [$];
    stim_t str_buf [$];
    stim_t directed_tbl [DIR_ROWS];

    int fail_cnt;
    int cycle_cnt;
    int items_sent;
    int results_seen;
    int done_seen;
    int errors_seen;
    int hold_left;
    logic hold_req;

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] lower;
        lower = c | 8'h20;
        if (c >= "0" && c <= "9")
        begin
            return {1'b1, c[3:0]};
        end
        if (lower >= "a" && lower <= "f")
        begin
            return {1'b1, 4'(lower - "a" + 8'd10)};
        end
        return 5'd0;
    endfunction

    function automatic logic [7:0] escape_char(input logic [7:0] c);
        case (c)
            ESC_B:   return CTL_BS;
            ESC_F:   return CTL_FF;
            ESC_N:   return CTL_LF;
            ESC_R:   return CTL_CR;
            ESC_T:   return CTL_TAB;
            default: return c;
        endcase
    endfunction

    task automatic emit(input logic [1:0] ev, input logic [7:0] d);
        dec_res[dec_n].ev   = ev;
        dec_res[dec_n].data = (ev == EV_BYTE) ? d : 8'h00;
        dec_res[dec_n].last = 1'b0;
        dec_n++;
    endtask

    task automatic clear_code();
        dec_hex_cnt  = 2'd0;
        dec_code     = 16'd0;
        dec_hex_stop = 1'b0;
    endtask

    task automatic decode_item(input logic [7:0] c, input logic fin);
        logic [4:0]  h;
        logic [15:0] cp;
        dec_n = 0;
        case (dec_mode)
            M_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    emit(EV_DONE, 8'h00);
                    dec_mode = M_WAIT;
                end
                else if (fin)
                begin
                    emit(EV_ERR, 8'h00);
                    dec_mode = M_WAIT;
                end
                else if (c == CH_BSLASH)
                begin
                    dec_mode = M_ESC;
                end
                else
                begin
                    emit(EV_BYTE, c);
                end
            end
            M_ESC:
            begin
                if (fin)
                begin
                    emit(EV_ERR, 8'h00);
                    dec_mode = M_WAIT;
                end
                else if (c == CH_U)
                begin
                    clear_code();
                    dec_mode = M_HEX;
                end
                else
                begin
                    emit(EV_BYTE, escape_char(c));
                    dec_mode = M_STR;
                end
            end
            M_HEX:
            begin
                if (fin)
                begin
                    emit(EV_ERR, 8'h00);
                    clear_code();
                    dec_mode = M_WAIT;
                end
                else
                begin
                    h = hex_nibble(c);
                    if (!dec_hex_stop && h[4])
                    begin
                        dec_code = {dec_code[11:0], h[3:0]};
                    end
                    else
                    begin
                        dec_hex_stop = 1'b1;
                    end
                    if (dec_hex_cnt == 2'd3)
                    begin
                        cp = dec_code;
                        if (cp < UTF_ONE_LIMIT)
                        begin
                            emit(EV_BYTE, cp[7:0]);
                        end
                        else if (cp < UTF_TWO_LIMIT)
                        begin
                            emit(EV_BYTE, UTF_LEAD2 | {3'd0, cp[10:6]});
                            emit(EV_BYTE, UTF_CONT | {2'd0, cp[5:0]});
                        end
                        else
                        begin
                            emit(EV_BYTE, UTF_LEAD3 | {4'd0, cp[15:12]});
                            emit(EV_BYTE, UTF_CONT | {2'd0, cp[11:6]});
                            emit(EV_BYTE, UTF_CONT | {2'd0, cp[5:0]});
                        end
                        clear_code();
                        dec_mode = M_STR;
                    end
                    else
                    begin
                        dec_hex_cnt = dec_hex_cnt + 2'd1;
                    end
                end
            end
            default:
            begin
                if (c != CH_QUOTE || fin)
                begin
                    emit(EV_ERR, 8'h00);
                    dec_mode = M_WAIT;
                end
                else
                begin
                    dec_mode = M_STR;
                end
            end
        endcase
        if (dec_n > 0)
        begin
            dec_res[dec_n - 1].last = 1'b1;
        end
    endtask

    function automatic stim_t row(input logic [7:0] d, input logic l);
        stim_t s;
        s.data  = d;
        s.last  = l;
        s.typed = 1'b0;
        s.want  = '0;
        return s;
    endfunction

    function automatic stim_t fixed(input logic [7:0] d, input logic l,
                                    input logic [1:0] ev, input logic [7:0] ob);
        stim_t s;
        s = row(d, l);
        s.typed     = 1'b1;
        s.want.ev   = ev;
        s.want.data = ob;
        s.want.last = 1'b1;
        return s;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10)
        begin
            return "0" + 8'(v);
        end
        return (upper ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        // keep quote and backslash out of plain text
        if (c == CH_QUOTE || c == CH_BSLASH)
        begin
            c = c ^ 8'h01;
        end
        return c;
    endfunction

    function automatic logic [7:0] escape_letter();
        logic [7:0] c;
        case ($urandom_range(0, 8))
            0:       c = ESC_B;
            1:       c = ESC_F;
            2:       c = ESC_N;
            3:       c = ESC_R;
            4:       c = ESC_T;
            5:       c = CH_QUOTE;
            6:       c = CH_BSLASH;
            7:       c = CH_SLASH;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return (c == CH_U) ? ESC_N : c;
    endfunction

    // one quoted string with random content, sometimes cut short
    task automatic build_string();
        int          len;
        int          cut;
        int          p;
        logic [15:0] cp;
        logic [7:0]  hx [4];
        str_buf.delete();
        str_buf.push_back(row(CH_QUOTE, 1'b0));
        len = $urandom_range(0, 8);
        for (int k = 0; k < len; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    str_buf.push_back(row(plain_char(), 1'b0));
                end
                4, 5, 6:
                begin
                    str_buf.push_back(row(CH_BSLASH, 1'b0));
                    str_buf.push_back(row(escape_letter(), 1'b0));
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       cp = 16'($urandom_range(0, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        default: cp = 16'($urandom_range(0, 16'hFFFF));
                    endcase
                    for (int j = 0; j < 4; j++)
                    begin
                        hx[j] = hex_char(cp[15 - 4 * j -: 4], 1'($urandom_range(0, 1)));
                    end
                    // a stray non-hex char stops accumulation
                    if ($urandom_range(0, 4) == 0)
                    begin
                        p = $urandom_range(0, 3);
                        hx[p] = ($urandom_range(0, 3) == 0) ? CH_QUOTE
                                                           : 8'($urandom_range(0, 255));
                    end
                    str_buf.push_back(row(CH_BSLASH, 1'b0));
                    str_buf.push_back(row(CH_U, 1'b0));
                    for (int j = 0; j < 4; j++)
                    begin
                        str_buf.push_back(row(hx[j], 1'b0));
                    end
                end
            endcase
        end
        if ($urandom_range(0, 99) < 82)
        begin
            str_buf.push_back(row(CH_QUOTE, 1'($urandom_range(0, 1))));
        end
        else
        begin
            cut = $urandom_range(0, str_buf.size() - 1);
            str_buf[cut].last = 1'b1;
            while (str_buf.size() > cut + 1)
            begin
                void'(str_buf.pop_back());
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // receiver: random stall, one long hold on request, result check
    initial
    begin
        int   r;
        int   stall_left;
        int   free_left;
        res_t want;
        stall_left   = 0;
        free_left    = 0;
        hold_left    = 0;
        hold_req     = 1'b0;
        results_seen = 0;
        done_seen    = 0;
        errors_seen  = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: event_res %0d out_byte %02h run_last %0d",
                           event_res, out_byte, run_last);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.ev == EV_DONE)
                    begin
                        done_seen++;
                    end
                    if (want.ev == EV_ERR)
                    begin
                        errors_seen++;
                    end
                    if (event_res !== want.ev)
                    begin
                        $error("event_res: expected %0d, actual %0d", want.ev, event_res);
                        fail_cnt++;
                    end
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
                        fail_cnt++;
                    end
                    if (run_last !== want.last)
                    begin
                        $error("run_last: expected %0d, actual %0d", want.last, run_last);
                        fail_cnt++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall <= 1'b0;
                free_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    free_left = $urandom_range(20, 50);
                    out_stall <= 1'b0;
                end
                else
                begin
                    free_left = $urandom_range(0, 4);
                    if (r < 50)
                    begin
                        stall_left = 0;
                    end
                    else if (r < 85)
                    begin
                        stall_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        stall_left = $urandom_range(6, 20);
                    end
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        out_stall <= 1'b1;
                    end
                    else
                    begin
                        out_stall <= 1'b0;
                    end
                end
            end
        end
    end

    // sender, decoder copy and end of run
    initial
    begin
        int    idx;
        int    gap_left;
        int    calm_left;
        int    r;
        int    rand_cnt;
        int    drain_a;
        int    drain_b;
        int    hold_idx;
        stim_t s;

        fail_cnt   = 0;
        items_sent = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        in_last    = 1'b0;
        dec_mode   = M_WAIT;
        clear_code();

        directed_tbl = '{
            fixed("A", 1'b0, EV_ERR, 8'h00),          // no opening quote
            fixed(CH_QUOTE, 1'b1, EV_ERR, 8'h00),     // opening quote ends the text
            row(CH_QUOTE, 1'b0),
            fixed(8'h00, 1'b0, EV_BYTE, 8'h00),
            fixed(8'hFF, 1'b0, EV_BYTE, 8'hFF),
            row(CH_BSLASH, 1'b0),
            row(ESC_N, 1'b0),
            row(CH_BSLASH, 1'b0),
            row(CH_U, 1'b0),
            row("F", 1'b0),
            row("F", 1'b0),
            row("F", 1'b0),
            row("F", 1'b0),                           // three-byte utf-8
            row(CH_BSLASH, 1'b0),
            row(CH_U, 1'b0),
            row("0", 1'b0),
            row("7", 1'b0),
            row("x", 1'b0),                           // stops the hex value
            row(CH_QUOTE, 1'b0),                      // swallowed as a hex char
            fixed(CH_QUOTE, 1'b1, EV_DONE, 8'h00),
            row(CH_QUOTE, 1'b0),
            row(CH_BSLASH, 1'b0),
            fixed("q", 1'b1, EV_ERR, 8'h00),          // text ends after backslash
            row(CH_QUOTE, 1'b0),
            row(CH_BSLASH, 1'b0),
            row(CH_U, 1'b0),
            row("1", 1'b0),
            fixed("a", 1'b1, EV_ERR, 8'h00)           // text ends inside \u
        };
        for (int k = 0; k < DIR_ROWS; k++)
        begin
            stim_q.push_back(directed_tbl[k]);
        end

        rand_cnt = 0;
        while (rand_cnt < RAND_ITEMS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                build_string();
            end
            else
            begin
                str_buf.delete();
                for (int k = $urandom_range(1, 4); k > 0; k--)
                begin
                    str_buf.push_back(row(8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1))));
                end
            end
            foreach (str_buf[k])
            begin
                stim_q.push_back(str_buf[k]);
            end
            rand_cnt += str_buf.size();
        end

        drain_a  = DIR_ROWS;
        drain_b  = DIR_ROWS + 120;
        hold_idx = DIR_ROWS + 40;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idx       = 0;
        gap_left  = 0;
        calm_left = 0;
        while (idx < stim_q.size())
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                s = stim_q[idx];
                decode_item(s.data, s.last);
                if (s.typed)
                begin
                    expected_q.push_back(s.want);
                end
                else
                begin
                    for (int k = 0; k < dec_n; k++)
                    begin
                        expected_q.push_back(dec_res[k]);
                    end
                end
                items_sent++;
                idx++;
            end
            if (in_valid && in_stall)
            begin
                // hold the offered item
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (idx < stim_q.size() &&
                     !((idx == drain_a || idx == drain_b) && expected_q.size() != 0))
            begin
                in_byte  <= stim_q[idx].data;
                in_last  <= stim_q[idx].last;
                in_valid <= 1'b1;
                if (idx == hold_idx)
                begin
                    hold_req = 1'b1;
                end
                // keep offering back to back while the receiver holds off or a calm run lasts
                if (hold_left > 0 || hold_req || calm_left > 0)
                begin
                    gap_left = 0;
                    if (calm_left > 0)
                    begin
                        calm_left--;
                    end
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                    begin
                        calm_left = $urandom_range(15, 40);
                        gap_left  = 0;
                    end
                    else if (r < 55)
                    begin
                        gap_left = 0;
                    end
                    else if (r < 82)
                    begin
                        gap_left = $urandom_range(1, 2);
                    end
                    else if (r < 95)
                    begin
                        gap_left = $urandom_range(3, 6);
                    end
                    else
                    begin
                        gap_left = $urandom_range(12, 30);
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end

        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d bytes (directed and random strings, escapes, \\u, noise)",
                 items_sent);
        $display("checked %0d results: %0d strings closed, %0d errors flagged",
                 results_seen, done_seen, errors_seen);
        if (fail_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
rtl/jsu_pkg.sv
rtl/json_string_unescaper_top.sv
test/json_string_unescaper_top_tb.sv
